/* sv/dual_pid_yaw_depth_controller_assert.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the dual PID yaw/depth controller
// Concurrent property shorthands sampled on clk, disabled while in reset.
// -----------------------------------------------------------------------------
`ifndef DUAL_PID_YAW_DEPTH_CONTROLLER_ASSERT_SVH
`define DUAL_PID_YAW_DEPTH_CONTROLLER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define DPYD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define DPYD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dpyd_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dpyd_pkg
// Widths, codes and shared types of the dual PID yaw/depth controller.
// -----------------------------------------------------------------------------
package dpyd_pkg;

	localparam int GAIN_W   = 24;
	localparam int LIMIT_W  = 15;
	localparam int DEPTH_W  = 16;
	localparam int POS_W    = 12;
	localparam int ERR_W    = 17;   // widest loop error (depth)
	localparam int SUM_W    = 32;
	localparam int SPEED_W  = 16;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_W   = 16;   // Q16 gains

	// Fixed depth loop gains, Q16
	localparam logic signed [GAIN_W-1:0] DEPTH_KP = GAIN_W'(6554);
	localparam logic signed [GAIN_W-1:0] DEPTH_KI = GAIN_W'(1311);
	localparam logic signed [GAIN_W-1:0] DEPTH_KD = GAIN_W'(6554);

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_YAW_KP      = 3'd0,
		REG_YAW_KI      = 3'd1,
		REG_YAW_KD      = 3'd2,
		REG_YAW_LIMIT   = 3'd3,
		REG_MOVE_LIMIT  = 3'd4,
		REG_TGT_DEPTH   = 3'd5,
		REG_CENTER_X    = 3'd6,
		REG_UNUSED      = 3'd7
	} cfg_index_t;

	// Gains and clamp of one loop
	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
		logic [LIMIT_W-1:0]       lim;
	} pid_gains_t;

endpackage

/* sv/dpyd_pid_core.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dpyd_pid_core
// One positional PID step: saturating integral, derivative, Q16 sum,
// truncation toward zero and symmetric clamp.
// -----------------------------------------------------------------------------
module dpyd_pid_core (
	input  logic signed [dpyd_pkg::ERR_W-1:0]   err,
	input  logic signed [dpyd_pkg::ERR_W-1:0]   last_err,
	input  logic signed [dpyd_pkg::SUM_W-1:0]   sum,
	input  dpyd_pkg::pid_gains_t                gains,
	output logic signed [dpyd_pkg::SUM_W-1:0]   sum_next,
	output logic signed [dpyd_pkg::SPEED_W-1:0] speed
);
	import dpyd_pkg::*;

	localparam int DIFF_W = ERR_W + 1;
	localparam int PP_W   = GAIN_W + ERR_W;
	localparam int PI_W   = GAIN_W + SUM_W;
	localparam int PD_W   = GAIN_W + DIFF_W;
	localparam int ACC_W  = PI_W + 2;
	localparam int QUO_W  = ACC_W - FRAC_W;

	localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(2**FRAC_W - 1);

	logic signed [SUM_W:0]    sum_wide;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PP_W-1:0]   prod_p;
	logic signed [PI_W-1:0]   prod_i;
	logic signed [PD_W-1:0]   prod_d;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  acc_adj;
	logic signed [QUO_W-1:0]  quo;
	logic signed [QUO_W-1:0]  lim_pos;

	always_comb begin
		sum_wide = (SUM_W+1)'(sum) + (SUM_W+1)'(err);
		if (sum_wide > SUM_MAX) begin
			sum_next = SUM_MAX[SUM_W-1:0];
		end else if (sum_wide < SUM_MIN) begin
			sum_next = SUM_MIN[SUM_W-1:0];
		end else begin
			sum_next = sum_wide[SUM_W-1:0];
		end

		diff   = DIFF_W'(err) - DIFF_W'(last_err);
		prod_p = gains.kp * err;
		prod_i = gains.ki * sum_next;
		prod_d = gains.kd * diff;
		acc    = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

		// truncate toward zero: bias negative totals before the shift
		acc_adj = acc[ACC_W-1] ? (acc + ROUND) : acc;
		quo     = acc_adj[ACC_W-1:FRAC_W];

		lim_pos = signed'(QUO_W'(gains.lim));
		if (quo > lim_pos) begin
			speed = SPEED_W'(lim_pos);
		end else if (quo < -lim_pos) begin
			speed = SPEED_W'(-lim_pos);
		end else begin
			speed = quo[SPEED_W-1:0];
		end
	end

endmodule

/* sv/dual_pid_yaw_depth_controller.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dual_pid_yaw_depth_controller
// Yaw and depth PID loops driven by a stream of control words.
// -----------------------------------------------------------------------------
//
//  channel | direction | handshake           | content
//  --------+-----------+---------------------+-----------------------------------
//  s_*     | in        | s_tvalid / s_tready | tuser: opcode, target_seen
//          |           |                     | tdata: target_x, depth
//  m_*     | out       | m_tvalid / m_tready | tdata: yaw_speed, move_speed
//  cfg_*   | in        | cfg_we (no wait)    | register index and data
//
//  One word per cycle sustained while results are taken. An accepted word is
//  held in the input stage; both PID steps run combinationally from it into
//  the result register. The loop state updates when the input stage retires,
//  which keeps ticks back to back without a bubble. Start, stop, ticks while not
//  tracking and the unused opcode retire without a result.
//  A stalled result register holds; the input stage then holds a pending tick,
//  and s_tready drops only while both are full.
//  Reset (arst_n low) clears tracking, both loop states and valid flags and
//  loads the register defaults.
// -----------------------------------------------------------------------------
`include "dual_pid_yaw_depth_controller_assert.svh"

module dual_pid_yaw_depth_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	// stream in
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [31:0]                      s_tdata,  // [11:0] target_x, [27:12] depth
	input  logic [2:0]                       s_tuser,  // [1:0] opcode, [2] target_seen
	// stream out
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [31:0]                      m_tdata,  // [15:0] yaw_speed, [31:16] move_speed
	// configuration
	input  logic                             cfg_we,
	input  logic [dpyd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dpyd_pkg::CFG_W-1:0]       cfg_data
);
	import dpyd_pkg::*;

	// ---------------------------------------------------------------- config
	logic signed [GAIN_W-1:0]  yaw_kp_q, yaw_ki_q, yaw_kd_q;
	logic [LIMIT_W-1:0]        yaw_limit_q, move_limit_q;
	logic [DEPTH_W-1:0]        tgt_depth_q;
	logic [POS_W-1:0]          center_x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_kp_q     <= GAIN_W'(655);
			yaw_ki_q     <= GAIN_W'(655);
			yaw_kd_q     <= GAIN_W'(328);
			yaw_limit_q  <= LIMIT_W'(300);
			move_limit_q <= LIMIT_W'(500);
			tgt_depth_q  <= DEPTH_W'(1000);
			center_x_q   <= POS_W'(320);
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				REG_YAW_KP:     yaw_kp_q     <= cfg_data;
				REG_YAW_KI:     yaw_ki_q     <= cfg_data;
				REG_YAW_KD:     yaw_kd_q     <= cfg_data;
				REG_YAW_LIMIT:  yaw_limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_MOVE_LIMIT: move_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_TGT_DEPTH:  tgt_depth_q  <= cfg_data[DEPTH_W-1:0];
				REG_CENTER_X:   center_x_q   <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// ----------------------------------------------------------- input stage
	logic                s1_valid_s1;
	opcode_t             opcode_s1;
	logic [POS_W-1:0]    target_x_s1;
	logic                seen_s1;
	logic [DEPTH_W-1:0]  depth_s1;

	logic is_tick;      // stage holds a tick that yields a result
	logic s1_retire;    // stage word leaves this cycle
	logic load_out;

	// state
	logic                     tracking_q;
	logic signed [SUM_W-1:0]  yaw_sum_q, depth_sum_q;
	logic signed [POS_W:0]    yaw_last_q;
	logic signed [ERR_W-1:0]  depth_last_q;

	assign is_tick   = s1_valid_s1 && (opcode_s1 == OP_TICK) && tracking_q;
	assign load_out  = is_tick && (!m_tvalid || m_tready);
	assign s1_retire = s1_valid_s1 && (!is_tick || load_out);
	assign s_tready  = !s1_valid_s1 || s1_retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_valid_s1 <= s_tvalid;
		end
	end

	// payload: capture on accept, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opcode_s1   <= opcode_t'(s_tuser[1:0]);
			seen_s1     <= s_tuser[2];
			target_x_s1 <= s_tdata[POS_W-1:0];
			depth_s1    <= s_tdata[POS_W+DEPTH_W-1:POS_W];
		end
	end

	// ----------------------------------------------------------- PID loops
	logic signed [POS_W:0]       yaw_err;
	logic signed [ERR_W-1:0]     depth_err;
	logic signed [SUM_W-1:0]     yaw_sum_next, depth_sum_next;
	logic signed [SPEED_W-1:0]   yaw_speed_c, move_speed_c;
	logic                        depth_ok;
	pid_gains_t                  yaw_gains, depth_gains;

	assign yaw_err   = signed'({1'b0, target_x_s1}) - signed'({1'b0, center_x_q});
	assign depth_err = signed'({1'b0, depth_s1}) - signed'({1'b0, tgt_depth_q});
	assign depth_ok  = (depth_s1 != '0);

	assign yaw_gains   = '{kp: yaw_kp_q, ki: yaw_ki_q, kd: yaw_kd_q, lim: yaw_limit_q};
	assign depth_gains = '{kp: DEPTH_KP, ki: DEPTH_KI, kd: DEPTH_KD, lim: move_limit_q};

	dpyd_pid_core u_yaw (
		.err      (ERR_W'(yaw_err)),
		.last_err (ERR_W'(yaw_last_q)),
		.sum      (yaw_sum_q),
		.gains    (yaw_gains),
		.sum_next (yaw_sum_next),
		.speed    (yaw_speed_c)
	);

	dpyd_pid_core u_depth (
		.err      (depth_err),
		.last_err (depth_last_q),
		.sum      (depth_sum_q),
		.gains    (depth_gains),
		.sum_next (depth_sum_next),
		.speed    (move_speed_c)
	);

	// Advance loop state when the stage word retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q   <= 1'b0;
			yaw_sum_q    <= '0;
			yaw_last_q   <= '0;
			depth_sum_q  <= '0;
			depth_last_q <= '0;
		end else if (s1_retire) begin
			case (opcode_s1)
				OP_START: begin
					// clear only the yaw loop; depth state is kept
					if (!tracking_q) begin
						tracking_q <= 1'b1;
						yaw_sum_q  <= '0;
						yaw_last_q <= '0;
					end
				end
				OP_STOP: tracking_q <= 1'b0;
				OP_TICK: begin
					if (tracking_q && seen_s1) begin
						yaw_sum_q  <= yaw_sum_next;
						yaw_last_q <= yaw_err;
					end
					if (tracking_q && depth_ok) begin
						depth_sum_q  <= depth_sum_next;
						depth_last_q <= depth_err;
					end
				end
				default: ;
			endcase
		end
	end

	// -------------------------------------------------------- result register
	logic                       out_valid_s2;
	logic signed [SPEED_W-1:0]  yaw_speed_s2, move_speed_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (load_out) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// zero a loop's field when it did not run on this tick
	always_ff @(posedge clk) begin
		if (load_out) begin
			yaw_speed_s2  <= seen_s1  ? yaw_speed_c  : '0;
			move_speed_s2 <= depth_ok ? move_speed_c : '0;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {move_speed_s2, yaw_speed_s2};

	// ------------------------------------------------------------ assertions
	`DPYD_ASSERT_SAME(a_load_only_tick, load_out,
		s1_valid_s1 && (opcode_s1 == OP_TICK) && tracking_q,
		"result loaded from a word that is not a tracking tick")

	`DPYD_ASSERT_SAME(a_yaw_clamp, load_out && seen_s1,
		(yaw_speed_c <= signed'({1'b0, yaw_limit_q})) &&
		(yaw_speed_c >= -signed'({1'b0, yaw_limit_q})),
		"yaw speed outside its limit")

	`DPYD_ASSERT_NEXT(a_start_clears, s1_retire && (opcode_s1 == OP_START) && !tracking_q,
		tracking_q && (yaw_sum_q == '0) && (yaw_last_q == '0),
		"start did not clear the yaw loop")

	`DPYD_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready && is_tick,
		is_tick,
		"pending tick lost while result stalled")

endmodule

/* sim/dpyd_result_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dpyd_result_checker
// Watches the control and result streams of the dual PID controller. It
// predicts the yaw and move speeds of every tick accepted while tracking and
// compares each result word, field by field, with the oldest prediction.
// -----------------------------------------------------------------------------
module dpyd_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [31:0]                    s_tdata,    // [11:0] target_x, [27:12] depth
	input  logic [2:0]                     s_tuser,    // [1:0] opcode, [2] target_seen
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [31:0]                    m_tdata,    // [15:0] yaw_speed, [31:16] move_speed
	input  logic                           cfg_we,
	input  logic [dpyd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dpyd_pkg::CFG_W-1:0]     cfg_data,
	output int                             fail_count,
	output int                             speeds_due
);
	import dpyd_pkg::*;

	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [SPEED_W-1:0] move;
		logic signed [SPEED_W-1:0] yaw;
	} speeds_t;

	typedef struct {
		longint sum;
		longint prev;
		longint speed;
	} loop_t;

	pid_gains_t          yaw_gains;
	logic [LIMIT_W-1:0]  move_lim;
	logic [DEPTH_W-1:0]  depth_goal;
	logic [POS_W-1:0]    center_x;
	logic                tracking;
	loop_t               yaw_loop;
	loop_t               depth_loop;
	speeds_t             speeds_q[$];

	// One positional PID step: saturating integral, Q16 sum truncated toward
	// zero, then clamped to the symmetric limit.
	function automatic loop_t pid_advance(loop_t st, longint err, longint kp,
			longint ki, longint kd, longint lim);
		loop_t  nx;
		longint acc;
		nx = st;
		nx.sum = st.sum + err;
		if (nx.sum > SUM_MAX) nx.sum = SUM_MAX;
		else if (nx.sum < SUM_MIN) nx.sum = SUM_MIN;
		acc = kp * err + ki * nx.sum + kd * (err - st.prev);
		nx.prev = err;
		nx.speed = acc / 64'sd65536;
		if (nx.speed > lim) nx.speed = lim;
		else if (nx.speed < -lim) nx.speed = -lim;
		return nx;
	endfunction

	task automatic report(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t ns dpyd_result_checker: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		speeds_t           want;
		speeds_t           got;
		opcode_t           op;
		logic [POS_W-1:0]  tx;
		logic [DEPTH_W-1:0] dep;
		if (!arst_n) begin
			yaw_gains.kp = GAIN_W'(655);
			yaw_gains.ki = GAIN_W'(655);
			yaw_gains.kd = GAIN_W'(328);
			yaw_gains.lim = LIMIT_W'(300);
			move_lim = LIMIT_W'(500);
			depth_goal = DEPTH_W'(1000);
			center_x = POS_W'(320);
			tracking = 1'b0;
			yaw_loop = '{0, 0, 0};
			depth_loop = '{0, 0, 0};
			speeds_q.delete();
		end else begin
			// compare the leaving result word with the oldest prediction
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (speeds_q.size() == 0) begin
					report($sformatf("result word yaw %0d move %0d with none expected",
						got.yaw, got.move));
				end else begin
					want = speeds_q.pop_front();
					if (got.yaw !== want.yaw)
						report($sformatf("yaw_speed expected %0d got %0d",
							want.yaw, got.yaw));
					if (got.move !== want.move)
						report($sformatf("move_speed expected %0d got %0d",
							want.move, got.move));
				end
			end
			// advance the loops on an accepted control word
			if (s_tvalid && s_tready) begin
				op = opcode_t'(s_tuser[1:0]);
				tx = s_tdata[11:0];
				dep = s_tdata[27:12];
				case (op)
				OP_START: begin
					if (!tracking) begin
						tracking = 1'b1;
						yaw_loop.sum = 0;
						yaw_loop.prev = 0;
					end
				end
				OP_STOP: begin
					tracking = 1'b0;
				end
				OP_TICK: begin
					if (tracking) begin
						want = '0;
						if (s_tuser[2]) begin
							yaw_loop = pid_advance(yaw_loop,
								longint'(tx) - longint'(center_x),
								longint'(yaw_gains.kp), longint'(yaw_gains.ki),
								longint'(yaw_gains.kd), longint'(yaw_gains.lim));
							want.yaw = yaw_loop.speed[SPEED_W-1:0];
						end
						if (dep != '0) begin
							depth_loop = pid_advance(depth_loop,
								longint'(dep) - longint'(depth_goal),
								longint'(DEPTH_KP), longint'(DEPTH_KI),
								longint'(DEPTH_KD), longint'(move_lim));
							want.move = depth_loop.speed[SPEED_W-1:0];
						end
						speeds_q.push_back(want);
					end
				end
				default: ;
				endcase
			end
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
				REG_YAW_KP:     yaw_gains.kp = cfg_data;
				REG_YAW_KI:     yaw_gains.ki = cfg_data;
				REG_YAW_KD:     yaw_gains.kd = cfg_data;
				REG_YAW_LIMIT:  yaw_gains.lim = cfg_data[LIMIT_W-1:0];
				REG_MOVE_LIMIT: move_lim = cfg_data[LIMIT_W-1:0];
				REG_TGT_DEPTH:  depth_goal = cfg_data[DEPTH_W-1:0];
				REG_CENTER_X:   center_x = cfg_data[POS_W-1:0];
				default: ;
				endcase
			end
		end
		speeds_due = speeds_q.size();
	end

endmodule

/* sim/tb_dual_pid_yaw_depth_controller.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_dual_pid_yaw_depth_controller
// Drives control words and register writes into the dual PID controller and
// lets a checker beside it predict and compare the speed words. A directed
// opening covers the opcodes and the no-target, no-depth and tracking cases,
// and random phases sweep register settings under varied sender idling and
// receiver stalls.
// -----------------------------------------------------------------------------
module tb_dual_pid_yaw_depth_controller;
	import dpyd_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata = '0;    // [11:0] target_x, [27:12] depth
	logic [2:0]           s_tuser = '0;    // [1:0] opcode, [2] target_seen
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;         // [15:0] yaw_speed, [31:16] move_speed
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int fail_count;
	int speeds_due;
	int idle_pct = 0;     // chance in a hundred that the sender skips a cycle
	int stall_pct = 0;    // chance in a hundred that the receiver stalls

	// setpoints last written, used to aim random words near the operating point
	logic [DEPTH_W-1:0] cur_goal = DEPTH_W'(1000);
	logic [POS_W-1:0]   cur_center = POS_W'(320);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	dual_pid_yaw_depth_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dpyd_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.speeds_due (speeds_due)
	);

	// Receiver: stall at random, redrawn every falling edge.
	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= stall_pct);
	end

	// Hard stop in case the controller hangs.
	initial begin
		#5_000_000;
		$display("tb_dual_pid_yaw_depth_controller: errors");
		$finish;
	end

	// Offer one control word at a falling edge and hold it until accepted;
	// return on the falling edge after the accepting rising edge.
	task automatic send_word(input opcode_t op, input logic [POS_W-1:0] tx,
			input logic seen, input logic [DEPTH_W-1:0] dep);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = {seen, op};
		s_tdata = {4'b0, dep, tx};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Hold the sender until every predicted speed word has left, then give
	// words that retire without a result time to clear the pipeline.
	task automatic drain();
		s_tvalid = 1'b0;
		while (speeds_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == REG_TGT_DEPTH) cur_goal = val[DEPTH_W-1:0];
		if (idx == REG_CENTER_X) cur_center = val[POS_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly gains that keep the outputs off the clamp, now and then any value.
	function automatic logic [CFG_W-1:0] rand_gain();
		if ($urandom_range(3) == 0) return CFG_W'($urandom);
		return CFG_W'($urandom_range(16383)) - CFG_W'(8192);
	endfunction

	function automatic logic [CFG_W-1:0] rand_limit();
		if ($urandom_range(1) == 0) return CFG_W'($urandom_range(1000));
		return CFG_W'($urandom_range(32767));
	endfunction

	// Load one register setting: the top extremes, the bottom extremes or
	// random values.
	task automatic load_setting(input int kind);
		drain();
		case (kind)
		1: begin
			write_reg(REG_YAW_KP, 24'h7FFFFF);
			write_reg(REG_YAW_KI, 24'h7FFFFF);
			write_reg(REG_YAW_KD, 24'h7FFFFF);
			write_reg(REG_YAW_LIMIT, 24'h007FFF);
			write_reg(REG_MOVE_LIMIT, 24'h007FFF);
			write_reg(REG_TGT_DEPTH, 24'h00FFFF);
			write_reg(REG_CENTER_X, 24'h000FFF);
		end
		2: begin
			write_reg(REG_YAW_KP, 24'h800000);
			write_reg(REG_YAW_KI, 24'h800000);
			write_reg(REG_YAW_KD, 24'h800000);
			write_reg(REG_YAW_LIMIT, '0);
			write_reg(REG_MOVE_LIMIT, '0);
			write_reg(REG_TGT_DEPTH, '0);
			write_reg(REG_CENTER_X, '0);
		end
		default: begin
			write_reg(REG_YAW_KP, rand_gain());
			write_reg(REG_YAW_KI, rand_gain());
			write_reg(REG_YAW_KD, rand_gain());
			write_reg(REG_YAW_LIMIT, rand_limit());
			write_reg(REG_MOVE_LIMIT, rand_limit());
			write_reg(REG_TGT_DEPTH, CFG_W'($urandom_range(65535)));
			write_reg(REG_CENTER_X, CFG_W'($urandom_range(4095)));
			// the spare index must leave every setting alone
			if (kind == 3) write_reg(REG_UNUSED, CFG_W'($urandom));
		end
		endcase
	endtask

	// Pace: 0 no idling, 1 sender idle, 2 receiver stalls, 3 both.
	task automatic set_pace(input int mode);
		case (mode)
		1: begin idle_pct = 48; stall_pct = 0;  end
		2: begin idle_pct = 0;  stall_pct = 48; end
		3: begin idle_pct = 13; stall_pct = 13; end
		default: begin idle_pct = 0; stall_pct = 0; end
		endcase
	endtask

	// Mostly ticks while tracking, with the odd start, stop and spare opcode;
	// positions and depths cluster near the setpoints part of the time.
	task automatic send_random_word();
		int                 pick;
		opcode_t            op;
		logic [POS_W-1:0]   tx;
		logic [DEPTH_W-1:0] dep;
		pick = $urandom_range(99);
		if (pick < 86) op = OP_TICK;
		else if (pick < 93) op = OP_START;
		else if (pick < 97) op = OP_STOP;
		else op = OP_NONE;
		if ($urandom_range(2) == 0)
			tx = cur_center + POS_W'($urandom_range(200)) - POS_W'(100);
		else
			tx = POS_W'($urandom_range(4095));
		pick = $urandom_range(99);
		if (pick < 12) dep = '0;
		else if (pick < 42)
			dep = cur_goal + DEPTH_W'($urandom_range(400)) - DEPTH_W'(200);
		else dep = DEPTH_W'($urandom_range(65535));
		send_word(op, tx, $urandom_range(99) < 75, dep);
	endtask

	initial begin : stimulus
		int ph;
		int i;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed opening with the reset settings.
		set_pace(0);
		send_word(OP_TICK, 12'd400, 1'b1, 16'd1200);    // not tracking: dropped
		send_word(OP_NONE, 12'd400, 1'b1, 16'd1200);    // spare opcode: dropped
		send_word(OP_STOP, 12'd0, 1'b0, 16'd0);         // stop while idle
		send_word(OP_START, 12'd0, 1'b0, 16'd0);
		send_word(OP_TICK, 12'd0, 1'b1, 16'd0);         // yaw only, no depth
		send_word(OP_TICK, 12'hFFF, 1'b1, 16'hFFFF);    // both extremes
		send_word(OP_TICK, 12'd320, 1'b1, 16'd1000);    // zero errors
		send_word(OP_TICK, 12'd100, 1'b0, 16'd1);       // no target
		send_word(OP_TICK, 12'hFFF, 1'b0, 16'd0);       // neither loop runs
		send_word(OP_START, 12'd0, 1'b0, 16'd0);        // already tracking
		send_word(OP_TICK, 12'd2000, 1'b1, 16'd500);
		send_word(OP_STOP, 12'd0, 1'b0, 16'd0);
		send_word(OP_TICK, 12'hFFF, 1'b1, 16'hFFFF);    // stopped: dropped
		send_word(OP_START, 12'd0, 1'b0, 16'd0);        // clears yaw, keeps depth
		send_word(OP_TICK, 12'd640, 1'b1, 16'd2000);
		send_word(OP_NONE, 12'd640, 1'b1, 16'd2000);    // spare opcode while tracking
		send_word(OP_TICK, 12'd0, 1'b1, 16'd0);
		send_word(OP_STOP, 12'd0, 1'b0, 16'd0);

		// Random phases: each loads a setting and runs under its own pace.
		for (ph = 0; ph < 8; ph++) begin
			load_setting((ph == 1 || ph == 2) ? ph : (ph == 3 ? 3 : 0));
			set_pace(ph % 4);
			for (i = 0; i < 190; i++) begin
				// let the sender sit until the block has emptied once mid-phase
				if (ph == 5 && i == 95) drain();
				send_random_word();
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && speeds_due == 0) begin
			$display("tb_dual_pid_yaw_depth_controller: clean");
		end else begin
			$display("tb_dual_pid_yaw_depth_controller: errors");
		end
		$finish;
	end

endmodule

/* dual_pid_yaw_depth_controller.f */
+incdir+sv
sv/dpyd_pkg.sv
sv/dpyd_pid_core.sv
sv/dual_pid_yaw_depth_controller.sv
sim/dpyd_result_checker.sv
sim/tb_dual_pid_yaw_depth_controller.sv
